// File: src/mhpq_pkg.sv
// Shared definitions for the max-heap priority queue: sizes, action and status codes,
// the stored entry layout and the child-selection result.
// Depends on nothing; the other files that use it refer to it by scoped names.
package mhpq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CH_W     = IDX_W + 2;
    localparam int FIELD_W  = 16;
    localparam int OCC_W    = 5;
    localparam int ACT_W    = 2;
    localparam int STAT_W   = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND  = 2'd0,
        ACT_BUILD   = 2'd1,
        ACT_INSERT  = 2'd2,
        ACT_EXTRACT = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [FIELD_W-1:0] id;
        logic [FIELD_W-1:0] prio;
    } entry_t;

    // Outcome of one sift-down comparison between a node and its children.
    typedef struct packed {
        logic move;
        logic right;
    } pick_t;

endpackage

// File: src/max_heap_priority_queue.sv
// Max-heap priority queue. Append, full, empty and builds of under two entries answer
// in the cycle after the request; insert climbs one level per S_UP_R/S_UP_C pass; extract
// reads the root and the tail, then descends one level per S_DN_L/S_DN_R/S_DN_C pass;
// build sifts each of count/2+1 nodes down the same way, from node count/2 to the root.
// One request at a time; results cannot be stalled.
// Reset (rst_n low, asynchronous) empties the queue; the RAM contents are not cleared.
module max_heap_priority_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [mhpq_pkg::ACT_W-1:0]   action,
    input  logic [mhpq_pkg::FIELD_W-1:0] proc_id,
    input  logic [mhpq_pkg::FIELD_W-1:0] prio,
    output logic                         done,
    output logic [mhpq_pkg::STAT_W-1:0]  status,
    output logic [mhpq_pkg::FIELD_W-1:0] out_id,
    output logic [mhpq_pkg::FIELD_W-1:0] out_prio,
    output logic [mhpq_pkg::OCC_W-1:0]   occupancy
);

    // One-hot sequencer. The entry being moved ("cur") is held in a register while
    // the hole it leaves travels through the RAM; it is written once, at the end.
    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_B_RD = 10'b00_0000_0010,
        S_B_LD = 10'b00_0000_0100,
        S_X_RD = 10'b00_0000_1000,
        S_X_LD = 10'b00_0001_0000,
        S_DN_L = 10'b00_0010_0000,
        S_DN_R = 10'b00_0100_0000,
        S_DN_C = 10'b00_1000_0000,
        S_UP_R = 10'b01_0000_0000,
        S_UP_C = 10'b10_0000_0000
    } state_t;

    state_t                        state_reg, state_next;
    mhpq_pkg::action_t             mode_reg, mode_next;
    mhpq_pkg::entry_t              cur_reg, cur_next;
    mhpq_pkg::entry_t              left_reg, left_next;
    mhpq_pkg::entry_t              top_reg, top_next;
    logic [mhpq_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic [mhpq_pkg::IDX_W-1:0]    bidx_reg, bidx_next;
    logic [mhpq_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                          done_reg, done_next;
    mhpq_pkg::status_t             status_reg, status_next;
    logic [mhpq_pkg::FIELD_W-1:0]  res_id_reg, res_id_next;
    logic [mhpq_pkg::FIELD_W-1:0]  res_prio_reg, res_prio_next;

    logic                          accept;
    mhpq_pkg::action_t             act;
    logic                          full;
    logic                          finish;
    logic                          sift_end;

    logic                          ram_we;
    logic [mhpq_pkg::IDX_W-1:0]    ram_waddr;
    mhpq_pkg::entry_t              ram_wdata;
    logic [mhpq_pkg::IDX_W-1:0]    ram_raddr;
    mhpq_pkg::entry_t              ram_rdata;

    logic [mhpq_pkg::CH_W-1:0]     left_idx;
    logic [mhpq_pkg::CH_W-1:0]     right_idx;
    logic [mhpq_pkg::CH_W-1:0]     count_ext;
    logic                          has_left;
    logic                          has_right;
    logic [mhpq_pkg::IDX_W-1:0]    parent_idx;
    mhpq_pkg::pick_t               pick;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign act    = mhpq_pkg::action_t'(action);
    assign full   = (count_reg >= mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY));

    // Child and parent positions of the current node. Children are computed wide
    // enough that they never wrap before the compare against the entry count.
    assign left_idx   = mhpq_pkg::CH_W'({idx_reg, 1'b1});
    assign right_idx  = left_idx + mhpq_pkg::CH_W'(1);
    assign count_ext  = mhpq_pkg::CH_W'(count_reg);
    assign has_left   = left_idx < count_ext;
    assign has_right  = right_idx < count_ext;
    assign parent_idx = mhpq_pkg::IDX_W'((idx_reg - mhpq_pkg::IDX_W'(1)) >> 1);

    mhpq_ram #(
        .WIDTH ($bits(mhpq_pkg::entry_t)),
        .DEPTH (mhpq_pkg::CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // In S_DN_C the RAM output holds the right child; the left child was latched earlier.
    mhpq_sel u_sel (
        .cur_prio   (cur_reg.prio),
        .left_prio  (left_reg.prio),
        .right_prio (ram_rdata.prio),
        .has_right  (has_right),
        .pick       (pick)
    );

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        cur_next      = cur_reg;
        left_next     = left_reg;
        top_next      = top_reg;
        idx_next      = idx_reg;
        bidx_next     = bidx_reg;
        count_next    = count_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        res_id_next   = res_id_reg;
        res_prio_next = res_prio_reg;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = cur_reg;
        ram_raddr     = idx_reg;
        finish        = 1'b0;
        sift_end      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next     = act;
                    res_id_next   = '0;
                    res_prio_next = '0;
                    status_next   = mhpq_pkg::ST_OK;
                    case (act)
                        mhpq_pkg::ACT_APPEND:
                        begin
                            done_next = 1'b1;
                            if (full)
                            begin
                                status_next = mhpq_pkg::ST_FULL;
                            end
                            else
                            begin
                                // A raw append lands at the tail and is not ordered.
                                ram_we     = 1'b1;
                                ram_waddr  = mhpq_pkg::IDX_W'(count_reg);
                                ram_wdata  = '{id: proc_id, prio: prio};
                                count_next = count_reg + mhpq_pkg::CNT_W'(1);
                            end
                        end
                        mhpq_pkg::ACT_INSERT:
                        begin
                            if (full)
                            begin
                                done_next   = 1'b1;
                                status_next = mhpq_pkg::ST_FULL;
                            end
                            else
                            begin
                                cur_next   = '{id: proc_id, prio: prio};
                                idx_next   = mhpq_pkg::IDX_W'(count_reg);
                                count_next = count_reg + mhpq_pkg::CNT_W'(1);
                                state_next = S_UP_R;
                            end
                        end
                        mhpq_pkg::ACT_BUILD:
                        begin
                            if (count_reg < mhpq_pkg::CNT_W'(2))
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                // Start at node count/2, one past the last node that can have a child.
                                bidx_next  = mhpq_pkg::IDX_W'(count_reg >> 1);
                                ram_raddr  = mhpq_pkg::IDX_W'(count_reg >> 1);
                                state_next = S_B_LD;
                            end
                        end
                        mhpq_pkg::ACT_EXTRACT:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = mhpq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ram_raddr  = '0;
                                state_next = S_X_RD;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_B_RD:
            begin
                ram_raddr  = bidx_reg;
                state_next = S_B_LD;
            end

            S_B_LD:
            begin
                cur_next   = ram_rdata;
                idx_next   = bidx_reg;
                state_next = S_DN_L;
            end

            S_X_RD:
            begin
                // The root is the answer; the tail entry becomes the new root.
                top_next   = ram_rdata;
                ram_raddr  = mhpq_pkg::IDX_W'(count_reg - mhpq_pkg::CNT_W'(1));
                state_next = S_X_LD;
            end

            S_X_LD:
            begin
                cur_next   = ram_rdata;
                idx_next   = '0;
                count_next = count_reg - mhpq_pkg::CNT_W'(1);
                state_next = S_DN_L;
            end

            S_DN_L:
            begin
                if (!has_left)
                begin
                    sift_end = 1'b1;
                end
                else
                begin
                    ram_raddr  = mhpq_pkg::IDX_W'(left_idx);
                    state_next = S_DN_R;
                end
            end

            S_DN_R:
            begin
                left_next  = ram_rdata;
                ram_raddr  = mhpq_pkg::IDX_W'(right_idx);
                state_next = S_DN_C;
            end

            S_DN_C:
            begin
                if (pick.move)
                begin
                    // The larger child rises into the hole and the hole moves down.
                    ram_we     = 1'b1;
                    ram_waddr  = idx_reg;
                    ram_wdata  = pick.right ? ram_rdata : left_reg;
                    idx_next   = pick.right ? mhpq_pkg::IDX_W'(right_idx)
                                            : mhpq_pkg::IDX_W'(left_idx);
                    state_next = S_DN_L;
                end
                else
                begin
                    sift_end = 1'b1;
                end
            end

            S_UP_R:
            begin
                if (idx_reg == '0)
                begin
                    ram_we = 1'b1;
                    finish = 1'b1;
                end
                else
                begin
                    ram_raddr  = parent_idx;
                    state_next = S_UP_C;
                end
            end

            S_UP_C:
            begin
                ram_we = 1'b1;
                if (ram_rdata.prio >= cur_reg.prio)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    // The parent drops into the hole and the hole climbs one level.
                    ram_wdata  = ram_rdata;
                    idx_next   = parent_idx;
                    state_next = S_UP_R;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A sift-down ends by placing the held entry; a build then moves to the
        // next lower node until the root has been sifted.
        if (sift_end)
        begin
            ram_we    = 1'b1;
            ram_waddr = idx_reg;
            ram_wdata = cur_reg;
            if ((mode_reg == mhpq_pkg::ACT_BUILD) && (bidx_reg != '0))
            begin
                bidx_next  = bidx_reg - mhpq_pkg::IDX_W'(1);
                state_next = S_B_RD;
            end
            else
            begin
                finish = 1'b1;
            end
        end

        if (finish)
        begin
            done_next   = 1'b1;
            state_next  = S_IDLE;
            status_next = mhpq_pkg::ST_OK;
            if (mode_reg == mhpq_pkg::ACT_EXTRACT)
            begin
                res_id_next   = top_reg.id;
                res_prio_next = top_reg.prio;
            end
            else
            begin
                res_id_next   = '0;
                res_prio_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            mode_reg   <= mhpq_pkg::ACT_APPEND;
            status_reg <= mhpq_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            mode_reg   <= mode_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        left_reg     <= left_next;
        top_reg      <= top_next;
        idx_reg      <= idx_next;
        bidx_reg     <= bidx_next;
        res_id_reg   <= res_id_next;
        res_prio_reg <= res_prio_next;
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign out_id    = res_id_reg;
    assign out_prio  = res_prio_reg;
    assign occupancy = mhpq_pkg::OCC_W'(count_reg);

    // A result is only ever presented once the sequencer is back in idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a request is still in progress");

    // The entry count never exceeds the store size.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY))
        else $error("entry count beyond capacity");

    // Extract on an empty store answers at once with the empty status.
    a_empty_extract: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (act == mhpq_pkg::ACT_EXTRACT) && (count_reg == '0))
        |=> (done && (status == mhpq_pkg::ST_EMPTY) && (count_reg == '0)))
        else $error("extract on empty store not reported");

    // Append or insert on a full store answers at once and leaves the count alone.
    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && full && ((act == mhpq_pkg::ACT_APPEND) || (act == mhpq_pkg::ACT_INSERT)))
        |=> (done && (status == mhpq_pkg::ST_FULL) && $stable(count_reg)))
        else $error("push on full store not reported");

    // A result with an error status never carries a nonzero entry.
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != mhpq_pkg::ST_OK)) |-> ((out_id == '0) && (out_prio == '0)))
        else $error("error result carries a payload");

endmodule

// File: src/mhpq_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Standalone; used for the heap entry store.
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/mhpq_sel.sv
// Child selection for one sift-down level of the heap.
// Depends on mhpq_pkg for field widths and the pick_t result type.
module mhpq_sel (
    input  logic [mhpq_pkg::FIELD_W-1:0] cur_prio,
    input  logic [mhpq_pkg::FIELD_W-1:0] left_prio,
    input  logic [mhpq_pkg::FIELD_W-1:0] right_prio,
    input  logic                         has_right,
    output mhpq_pkg::pick_t              pick
);

    logic                         left_gt;
    logic                         right_gt;
    logic [mhpq_pkg::FIELD_W-1:0] best_prio;

    // A child must be strictly larger to move; on a tie between children the left wins.
    assign left_gt    = left_prio > cur_prio;
    assign best_prio  = left_gt ? left_prio : cur_prio;
    assign right_gt   = has_right && (right_prio > best_prio);
    assign pick.move  = left_gt || right_gt;
    assign pick.right = right_gt;

endmodule

// File: tb/max_heap_priority_queue_test.sv
// Self-checking testbench for the max-heap priority queue (append, build, insert, extract).
// A queue-fed driver and a monitor check each result against a built-in heap predictor.
// Depends on mhpq_pkg and max_heap_priority_queue only.
`timescale 1ns / 100ps

module max_heap_priority_queue_test;

    // The run stops with a failure if it has not finished after this many cycles.
    // The slowest correct run is far below this: the directed requests and at least
    // RANDOM_COUNT random ones, each at most one full build plus the longest sender gap.
    localparam int CYCLE_LIMIT   = 1_000_000;
    // Quiet time after the last result, longer than a full build of a full queue.
    localparam int DRAIN_CYCLES  = 200;
    localparam int RANDOM_COUNT  = 900;

    // One request as the driver presents it to the block.
    typedef struct {
        mhpq_pkg::action_t            act;
        logic [mhpq_pkg::FIELD_W-1:0] id;
        logic [mhpq_pkg::FIELD_W-1:0] prio;
    } request_t;

    // One result as the block should report it.
    typedef struct {
        mhpq_pkg::status_t            status;
        logic [mhpq_pkg::FIELD_W-1:0] id;
        logic [mhpq_pkg::FIELD_W-1:0] prio;
        logic [mhpq_pkg::OCC_W-1:0]   occupancy;
    } outcome_t;

    logic                           clk;
    logic                           rst_n = 1'b0;
    logic                           start = 1'b0;
    mhpq_pkg::action_t              req_action = mhpq_pkg::ACT_APPEND;
    logic [mhpq_pkg::FIELD_W-1:0]   req_id = '0;
    logic [mhpq_pkg::FIELD_W-1:0]   req_prio = '0;
    logic                           busy;
    logic                           done;
    logic [mhpq_pkg::STAT_W-1:0]    status;
    logic [mhpq_pkg::FIELD_W-1:0]   out_id;
    logic [mhpq_pkg::FIELD_W-1:0]   out_prio;
    logic [mhpq_pkg::OCC_W-1:0]     occupancy;

    request_t pending_requests[$];   // requests not yet offered to the block
    outcome_t awaited_outcomes[$];   // predicted results, oldest first
    int       failures = 0;
    int       cycle_count = 0;
    int       gap_left = 0;          // idle cycles still to insert before the next request
    int       steady_left = 0;       // requests still to send back to back
    int       planned_count = 0;     // queue occupancy as the stimulus generator sees it

    // Predictor state: a shadow copy of the heap contents and its entry count.
    mhpq_pkg::entry_t shadow_heap[mhpq_pkg::CAPACITY];
    int               shadow_count = 0;

    max_heap_priority_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .action    (req_action),
        .proc_id   (req_id),
        .prio      (req_prio),
        .done      (done),
        .status    (status),
        .out_id    (out_id),
        .out_prio  (out_prio),
        .occupancy (occupancy)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Heap predictor
    // ------------------------------------------------------------------

    function automatic void swap_shadow(int a, int b);
        mhpq_pkg::entry_t tmp;
        tmp = shadow_heap[a];
        shadow_heap[a] = shadow_heap[b];
        shadow_heap[b] = tmp;
    endfunction

    // Push a node down until both children are no larger. A strictly larger child is
    // needed to move, and the left child is tried first, so on a tie between the two
    // children the left one wins. A node with only a left child still compares it.
    function automatic void sink_node(int node);
        int idx;
        int left;
        int right;
        int big;
        idx = node;
        while (idx < shadow_count)
        begin
            left  = 2 * idx + 1;
            right = left + 1;
            big   = idx;
            if (left < shadow_count && shadow_heap[left].prio > shadow_heap[big].prio)
                big = left;
            if (right < shadow_count && shadow_heap[right].prio > shadow_heap[big].prio)
                big = right;
            if (big == idx)
                break;
            swap_shadow(idx, big);
            idx = big;
        end
    endfunction

    // Raise a node while its parent holds a strictly smaller priority.
    function automatic void raise_node(int node);
        int idx;
        int parent;
        idx = node;
        while (idx > 0)
        begin
            parent = (idx - 1) / 2;
            if (shadow_heap[parent].prio >= shadow_heap[idx].prio)
                break;
            swap_shadow(parent, idx);
            idx = parent;
        end
    endfunction

    // Apply one accepted request to the shadow heap and return the result it must give.
    function automatic outcome_t apply_request(request_t req);
        outcome_t res;
        res = '{status: mhpq_pkg::ST_OK, id: '0, prio: '0, occupancy: '0};
        case (req.act)
            mhpq_pkg::ACT_APPEND, mhpq_pkg::ACT_INSERT:
            begin
                if (shadow_count >= mhpq_pkg::CAPACITY)
                    res.status = mhpq_pkg::ST_FULL;
                else
                begin
                    shadow_heap[shadow_count] = '{id: req.id, prio: req.prio};
                    shadow_count++;
                    if (req.act == mhpq_pkg::ACT_INSERT)
                        raise_node(shadow_count - 1);
                end
            end
            mhpq_pkg::ACT_BUILD:
            begin
                for (int n = shadow_count / 2; n >= 0; n--)
                    sink_node(n);
            end
            default:
            begin
                if (shadow_count == 0)
                    res.status = mhpq_pkg::ST_EMPTY;
                else
                begin
                    res.id   = shadow_heap[0].id;
                    res.prio = shadow_heap[0].prio;
                    shadow_count--;
                    shadow_heap[0] = shadow_heap[shadow_count];
                    sink_node(0);
                end
            end
        endcase
        res.occupancy = shadow_count[mhpq_pkg::OCC_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Queue a request and keep the generator's view of the occupancy current, so that
    // random sequences can be steered towards a full or an empty queue.
    task automatic add_request(mhpq_pkg::action_t act, logic [mhpq_pkg::FIELD_W-1:0] id,
                               logic [mhpq_pkg::FIELD_W-1:0] prio);
        pending_requests.push_back('{act: act, id: id, prio: prio});
        if ((act == mhpq_pkg::ACT_APPEND || act == mhpq_pkg::ACT_INSERT)
            && planned_count < mhpq_pkg::CAPACITY)
            planned_count++;
        else if (act == mhpq_pkg::ACT_EXTRACT && planned_count > 0)
            planned_count--;
    endtask

    // Priorities are often drawn from a tiny range so that ties are common.
    function automatic logic [mhpq_pkg::FIELD_W-1:0] pick_prio();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            return mhpq_pkg::FIELD_W'($urandom_range(0, 7));
        else if (roll < 40)
            return ($urandom_range(0, 1) == 1) ? '1 : '0;
        else
            return mhpq_pkg::FIELD_W'($urandom);
    endfunction

    function automatic logic [mhpq_pkg::FIELD_W-1:0] pick_id();
        return mhpq_pkg::FIELD_W'($urandom);
    endfunction

    // Sender gaps: mostly none or short, a few long, with occasional back-to-back runs.
    function automatic int next_gap();
        int roll;
        if (steady_left > 0)
        begin
            steady_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            steady_left = $urandom_range(20, 60);
            return 0;
        end
        else if (roll < 45)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers the next pending request and predicts its result once accepted.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : driver
        request_t next_req;
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            // A request is taken at an edge where start is high and busy is low.
            if (start && !busy)
            begin
                awaited_outcomes.push_back(
                    apply_request('{act: req_action, id: req_id, prio: req_prio}));
                gap_left = next_gap();
            end
            // While the block is busy the current request simply stays on the ports.
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    next_req = pending_requests.pop_front();
                    req_action <= next_req.act;
                    req_id     <= next_req.id;
                    req_prio   <= next_req.prio;
                    start      <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every done pulse is matched against the oldest prediction.
    // ------------------------------------------------------------------

    task automatic report_field(string name, int want, int got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        failures++;
    endtask

    always @(posedge clk)
    begin : monitor
        outcome_t want;
        if (rst_n && done)
        begin
            if (awaited_outcomes.size() == 0)
            begin
                $display({"%0t: unexpected result, expected none, ",
                          "actual status %0d id %0h prio %0h occupancy %0d"},
                         $time, status, out_id, out_prio, occupancy);
                failures++;
            end
            else
            begin
                want = awaited_outcomes.pop_front();
                if (status !== want.status)
                    report_field("status", want.status, status);
                if (out_id !== want.id)
                    report_field("out_id", want.id, out_id);
                if (out_prio !== want.prio)
                    report_field("out_prio", want.prio, out_prio);
                if (occupancy !== want.occupancy)
                    report_field("occupancy", want.occupancy, occupancy);
            end
        end
    end

    // Hard stop if the block stops answering.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------

    initial
    begin
        int queued;
        int pattern;
        int episode;
        int burst;

        // Directed part: empty and single-entry corners, extreme fields, ties on insert,
        // and a raw batch whose build leaves a parent with only a left child.
        add_request(mhpq_pkg::ACT_EXTRACT, '1, '1);           // extract from an empty queue
        add_request(mhpq_pkg::ACT_BUILD, '0, '0);             // build with nothing held
        add_request(mhpq_pkg::ACT_APPEND, '1, '1);
        add_request(mhpq_pkg::ACT_BUILD, '0, '0);             // build with a single entry
        add_request(mhpq_pkg::ACT_EXTRACT, '0, '0);
        add_request(mhpq_pkg::ACT_INSERT, '0, '0);
        add_request(mhpq_pkg::ACT_INSERT, 16'h0001, 16'h00ff);
        add_request(mhpq_pkg::ACT_INSERT, 16'haaaa, 16'h00ff); // equal to its parent, stays put
        add_request(mhpq_pkg::ACT_INSERT, 16'h5555, 16'hffff); // climbs to the root
        add_request(mhpq_pkg::ACT_EXTRACT, '0, '0);
        add_request(mhpq_pkg::ACT_EXTRACT, '0, '0);            // lone left child is smaller
        add_request(mhpq_pkg::ACT_EXTRACT, '0, '0);
        add_request(mhpq_pkg::ACT_EXTRACT, '0, '0);
        for (int n = 1; n <= 6; n++)
            add_request(mhpq_pkg::ACT_APPEND, 16'h0100 + mhpq_pkg::FIELD_W'(n),
                        mhpq_pkg::FIELD_W'(n));
        add_request(mhpq_pkg::ACT_BUILD, '0, '0);  // six entries: node 2 has a lone left child
        add_request(mhpq_pkg::ACT_EXTRACT, '0, '0);
        add_request(mhpq_pkg::ACT_EXTRACT, '0, '0);
        add_request(mhpq_pkg::ACT_INSERT, 16'hc3c3, 16'h8000);

        // Random part, built from episodes that reach a full queue, drain it to empty,
        // build raw batches, or mix all actions. The first four episodes run each kind
        // once so that every one of them appears regardless of the seed.
        queued  = 0;
        episode = 0;
        while (queued < RANDOM_COUNT)
        begin
            pattern = (episode < 4) ? episode : $urandom_range(0, 3);
            episode++;
            case (pattern)
                0:
                begin
                    // Fill up, then push against the full queue a few times.
                    while (planned_count < mhpq_pkg::CAPACITY)
                    begin
                        add_request(($urandom_range(0, 4) == 0) ? mhpq_pkg::ACT_APPEND
                                                                 : mhpq_pkg::ACT_INSERT,
                                    pick_id(), pick_prio());
                        queued++;
                    end
                    burst = $urandom_range(1, 3);
                    repeat (burst)
                    begin
                        add_request(($urandom_range(0, 1) == 0) ? mhpq_pkg::ACT_APPEND
                                                                 : mhpq_pkg::ACT_INSERT,
                                    pick_id(), pick_prio());
                        queued++;
                    end
                end
                1:
                begin
                    // Drain to empty, then extract from the empty queue.
                    burst = planned_count + $urandom_range(1, 2);
                    repeat (burst)
                    begin
                        add_request(mhpq_pkg::ACT_EXTRACT, pick_id(), pick_prio());
                        queued++;
                    end
                end
                2:
                begin
                    // Raw appends, one build, then pull some entries out in order.
                    burst = $urandom_range(0, mhpq_pkg::CAPACITY - planned_count);
                    repeat (burst)
                    begin
                        add_request(mhpq_pkg::ACT_APPEND, pick_id(), pick_prio());
                        queued++;
                    end
                    add_request(mhpq_pkg::ACT_BUILD, pick_id(), pick_prio());
                    queued++;
                    burst = $urandom_range(0, planned_count);
                    repeat (burst)
                    begin
                        add_request(mhpq_pkg::ACT_EXTRACT, pick_id(), pick_prio());
                        queued++;
                    end
                end
                default:
                begin
                    // Free mix of all actions with random fields.
                    burst = $urandom_range(10, 30);
                    repeat (burst)
                    begin
                        case ($urandom_range(0, 9))
                            0, 1:
                                add_request(mhpq_pkg::ACT_APPEND, pick_id(), pick_prio());
                            2:
                                add_request(mhpq_pkg::ACT_BUILD, pick_id(), pick_prio());
                            3, 4, 5:
                                add_request(mhpq_pkg::ACT_INSERT, pick_id(), pick_prio());
                            default:
                                add_request(mhpq_pkg::ACT_EXTRACT, pick_id(), pick_prio());
                        endcase
                        queued++;
                    end
                end
            endcase
        end

        // Reset is held low from the start and released at a rising edge.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every request has been taken and every result has arrived, sampling
        // between edges, then give the block time to show any stray result.
        @(negedge clk);
        while (pending_requests.size() > 0 || start || awaited_outcomes.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
